>>> sv/ksr_pkg.sv
// ----------------------------------------------------------------------------
// ksr_pkg: shared types, constants and fixed-point helpers
// Q16.16 data format, command and status structs for the stencil block.
// ----------------------------------------------------------------------------
package ksr_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef logic signed [DATA_WIDTH-1:0] q_t;

    localparam q_t QMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam q_t QMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam q_t HALF = q_t'(1) <<< (FRAC_BITS - 1);
    localparam q_t ONE  = q_t'(1) <<< FRAC_BITS;

    localparam logic [CFG_IDX_W-1:0] REG_DX_INV = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MU_ADV = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MU_HYP = 2'd2;

    // operation codes for the shared multiply/add datapath
    typedef enum logic [2:0] {
        OP_MUL = 3'd0,
        OP_ADD = 3'd1,
        OP_SUB = 3'd2,
        OP_NEG = 3'd3
    } alu_op_t;

    // one node's neighbour set handed to the datapath
    typedef struct packed {
        q_t   c;
        q_t   up;
        q_t   upp;
        q_t   um;
        q_t   umm;
        logic last;
    } node_t;

    typedef struct packed {
        logic  start;
        node_t nd;
    } dp_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } dp_sts_t;

    function automatic q_t qadd(input q_t a, input q_t b, output logic f);
        logic signed [DATA_WIDTH:0] s;
        s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
        f = (s[DATA_WIDTH] != s[DATA_WIDTH-1]);
        if (!f)                return s[DATA_WIDTH-1:0];
        else if (s[DATA_WIDTH]) return QMIN;
        else                   return QMAX;
    endfunction

    function automatic q_t qsub(input q_t a, input q_t b, output logic f);
        logic signed [DATA_WIDTH:0] s;
        s = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
        f = (s[DATA_WIDTH] != s[DATA_WIDTH-1]);
        if (!f)                return s[DATA_WIDTH-1:0];
        else if (s[DATA_WIDTH]) return QMIN;
        else                   return QMAX;
    endfunction

endpackage

>>> sv/ksr_stream_if.sv
// ----------------------------------------------------------------------------
// ksr_stream_if: valid/ready channel
// Carries a generic payload from a source to a sink.
// ----------------------------------------------------------------------------
interface ksr_stream_if #(
    parameter int W = 33
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/ksr_datapath.sv
// ----------------------------------------------------------------------------
// ksr_datapath: sequenced fixed-point evaluation of one node
// One rounded multiply or saturating add per cycle, over a fixed program.
// ----------------------------------------------------------------------------
module ksr_datapath
    import ksr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    output dp_sts_t             sts,
    input  logic [30:0]         dx_inv,
    input  q_t                  mu_adv,
    input  q_t                  mu_hyp,
    output q_t                  res_value,
    output logic                res_last,
    output logic                res_sat
);

    localparam int NSTEP = 24;
    localparam int SW    = $clog2(NSTEP + 1);
    localparam int NR    = 16;
    localparam int RW    = $clog2(NR);

    // scratch register file; fixed slots
    localparam logic [RW-1:0] R_C = 0, R_UP = 1, R_UPP = 2, R_UM = 3, R_UMM = 4,
        R_DX = 5, R_HALF = 6, R_HDX = 7, R_DX2 = 8, R_T0 = 9, R_T1 = 10,
        R_T2 = 11, R_UX = 12, R_U2X = 13, R_UXX = 14, R_R = 15;

    typedef struct packed {
        alu_op_t       op;
        logic [RW-1:0] a;
        logic [RW-1:0] b;
        logic [RW-1:0] d;
    } instr_t;

    function automatic instr_t prog(input logic [SW-1:0] s);
        case (s)
            0:  return '{OP_MUL, R_HALF, R_DX, R_HDX};
            1:  return '{OP_MUL, R_DX, R_DX, R_DX2};
            2:  return '{OP_SUB, R_UP, R_UM, R_T0};
            3:  return '{OP_MUL, R_HDX, R_T0, R_UX};
            4:  return '{OP_MUL, R_UP, R_UP, R_T0};
            5:  return '{OP_MUL, R_UM, R_UM, R_T1};
            6:  return '{OP_SUB, R_T0, R_T1, R_T0};
            7:  return '{OP_MUL, R_HDX, R_T0, R_U2X};
            8:  return '{OP_ADD, R_UP, R_UM, R_T0};
            9:  return '{OP_ADD, R_C, R_C, R_T1};
            10: return '{OP_SUB, R_T0, R_T1, R_T0};
            11: return '{OP_MUL, R_DX2, R_T0, R_UXX};
            12: return '{OP_ADD, R_UPP, R_C, R_T0};
            13: return '{OP_ADD, R_UP, R_UP, R_T1};
            14: return '{OP_SUB, R_T0, R_T1, R_T0};
            15: return '{OP_MUL, R_DX2, R_T0, R_T2};
            16: return '{OP_ADD, R_UMM, R_C, R_T0};
            17: return '{OP_ADD, R_UM, R_UM, R_T1};
            18: return '{OP_SUB, R_T0, R_T1, R_T0};
            19: return '{OP_MUL, R_DX2, R_T0, R_T0};
            20: return '{OP_ADD, R_T2, R_T0, R_T0};
            21: return '{OP_ADD, R_UXX, R_UXX, R_T1};
            22: return '{OP_SUB, R_T0, R_T1, R_T0};
            default: return '{OP_MUL, R_DX2, R_T0, R_T2};
        endcase
    endfunction

    // tail program: r = (-mua)*ux - half*u2x - uxx - muh*u4; u4 in R_T2
    function automatic instr_t tail(input logic [SW-1:0] s);
        case (s)
            0: return '{OP_NEG, R_HALF, R_HALF, R_T0};  // a set to mua below
            1: return '{OP_MUL, R_T0, R_UX, R_R};
            2: return '{OP_MUL, R_HALF, R_U2X, R_T0};
            3: return '{OP_SUB, R_R, R_T0, R_R};
            4: return '{OP_SUB, R_R, R_UXX, R_R};
            5: return '{OP_MUL, R_T1, R_T2, R_T0};      // t1 holds muh
            default: return '{OP_SUB, R_R, R_T0, R_R};
        endcase
    endfunction

    localparam int NTAIL = 7;
    localparam int TOTAL = NSTEP + NTAIL;
    localparam int PW    = $clog2(TOTAL + 1);

    q_t               rf_reg [NR];
    q_t               rf_next [NR];
    logic [PW-1:0]    pc_reg, pc_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             sat_reg, sat_next;
    logic             last_reg, last_next;
    instr_t           ins;
    q_t               opa, opb, alu_res;
    logic             alu_f;
    logic             mul_f;
    q_t               mul_res;
    q_t               dxc;

    assign dxc = q_t'({1'b0, dx_inv});

    always_comb
    begin
        if (pc_reg < PW'(NSTEP))
            ins = prog(SW'(pc_reg));
        else
            ins = tail(SW'(pc_reg - PW'(NSTEP)));
    end

    always_comb
    begin
        opa = rf_reg[ins.a];
        opb = rf_reg[ins.b];
        if (pc_reg == PW'(NSTEP))
            opa = mu_adv;
    end

    // exact product, round half away from zero, saturate
    always_comb
    begin
        logic                      neg;
        logic [DATA_WIDTH-1:0]     ma, mb;
        logic [2*DATA_WIDTH-1:0]   p;
        logic [2*DATA_WIDTH-1:0]   pr;
        logic [2*DATA_WIDTH-1:0]   m;
        logic [DATA_WIDTH-1:0]     lim;
        neg = opa[DATA_WIDTH-1] ^ opb[DATA_WIDTH-1];
        ma  = opa[DATA_WIDTH-1] ? DATA_WIDTH'(-opa) : opa;
        mb  = opb[DATA_WIDTH-1] ? DATA_WIDTH'(-opb) : opb;
        p   = (2*DATA_WIDTH)'(ma) * (2*DATA_WIDTH)'(mb);
        pr  = p + (2*DATA_WIDTH)'(HALF);
        m   = pr >> FRAC_BITS;
        lim = neg ? QMIN : QMAX;
        mul_f = (m > (2*DATA_WIDTH)'(lim));
        if (mul_f)
            m = (2*DATA_WIDTH)'(lim);
        mul_res = neg ? q_t'(-m[DATA_WIDTH-1:0]) : q_t'(m[DATA_WIDTH-1:0]);
    end

    always_comb
    begin
        alu_f = 1'b0;
        case (ins.op)
            OP_MUL: begin alu_res = mul_res; alu_f = mul_f; end
            OP_ADD: alu_res = qadd(opa, opb, alu_f);
            OP_SUB: alu_res = qsub(opa, opb, alu_f);
            OP_NEG:
            begin
                alu_f   = (opa == QMIN);
                alu_res = alu_f ? QMAX : -opa;
            end
            default: alu_res = '0;
        endcase
    end

    always_comb
    begin
        rf_next   = rf_reg;
        pc_next   = pc_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        sat_next  = sat_reg;
        last_next = last_reg;
        if (cmd.start && !busy_reg)
        begin
            rf_next[R_C]    = cmd.nd.c;
            rf_next[R_UP]   = cmd.nd.up;
            rf_next[R_UPP]  = cmd.nd.upp;
            rf_next[R_UM]   = cmd.nd.um;
            rf_next[R_UMM]  = cmd.nd.umm;
            rf_next[R_DX]   = dxc;
            rf_next[R_HALF] = HALF;
            last_next = cmd.nd.last;
            sat_next  = 1'b0;
            pc_next   = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rf_next[ins.d] = alu_res;
            sat_next = sat_reg | alu_f;
            // muh is parked in t1 ahead of the last multiply
            if (pc_reg == PW'(NSTEP + 4))
                rf_next[R_T1] = mu_hyp;
            if (pc_reg == PW'(TOTAL - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
                pc_next = pc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rf_reg   <= rf_next;
        sat_reg  <= sat_next;
        last_reg <= last_next;
    end

    assign sts.busy  = busy_reg;
    assign sts.done  = done_reg;
    assign res_value = rf_reg[R_R];
    assign res_last  = last_reg;
    assign res_sat   = sat_reg;

`ifndef SYNTHESIS
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("done held");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg)) else $error("done without busy");
    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> pc_reg < PW'(TOTAL)) else $error("pc out of range");
`endif

endmodule

>>> sv/ksr_ctrl.sv
// ----------------------------------------------------------------------------
// ksr_ctrl: sample window and node sequencer
// Holds the window, builds zero to three node jobs per sample, hands
// each to the datapath and returns results through an output register.
// ----------------------------------------------------------------------------
module ksr_ctrl
    import ksr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  q_t      in_sample,
    input  logic    in_last,
    output logic    out_valid,
    input  logic    out_ready,
    output q_t      out_value,
    output logic    out_last,
    output logic    out_sat,
    output dp_cmd_t cmd,
    input  dp_sts_t sts,
    input  q_t      dp_value,
    input  logic    dp_last,
    input  logic    dp_sat
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RUN  = 4'b0010,
        S_OUT  = 4'b0100,
        S_NEXT = 4'b1000
    } state_t;

    state_t        state_reg, state_next;
    q_t            win_reg [4];
    q_t            win_next [4];
    logic [2:0]    seen_reg, seen_next;
    node_t         jobs_reg [3];
    node_t         jobs_next [3];
    logic [1:0]    njob_reg, njob_next;
    logic [1:0]    jidx_reg, jidx_next;
    logic          ov_reg, ov_next;
    q_t            ovv_reg, ovv_next;
    logic          ovl_reg, ovl_next;
    logic          ovs_reg, ovs_next;
    logic          accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        node_t      j;
        logic [1:0] n;
        q_t         x;
        state_next = state_reg;
        win_next   = win_reg;
        seen_next  = seen_reg;
        jobs_next  = jobs_reg;
        njob_next  = njob_reg;
        jidx_next  = jidx_reg;
        ov_next    = ov_reg;
        ovv_next   = ovv_reg;
        ovl_next   = ovl_reg;
        ovs_next   = ovs_reg;
        cmd        = '0;
        j          = '0;
        n          = '0;
        x          = in_sample;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (seen_reg >= 3'd2)
                    begin
                        j.c = win_reg[1]; j.up = win_reg[0]; j.upp = x;
                        j.um = (seen_reg >= 3'd3) ? win_reg[2] : '0;
                        j.umm = (seen_reg >= 3'd4) ? win_reg[3] : win_reg[1];
                        j.last = 1'b0;
                        jobs_next[n] = j;
                        n = n + 1'b1;
                    end
                    if (in_last)
                    begin
                        if (seen_reg >= 3'd1)
                        begin
                            j.c = win_reg[0]; j.up = x; j.upp = win_reg[0];
                            j.um = (seen_reg >= 3'd2) ? win_reg[1] : '0;
                            j.umm = (seen_reg >= 3'd3) ? win_reg[2] : win_reg[0];
                            j.last = 1'b0;
                            jobs_next[n] = j;
                            n = n + 1'b1;
                        end
                        j.c = x; j.up = '0; j.upp = x;
                        j.um = (seen_reg >= 3'd1) ? win_reg[0] : '0;
                        j.umm = (seen_reg >= 3'd2) ? win_reg[1] : x;
                        j.last = 1'b1;
                        jobs_next[n] = j;
                        n = n + 1'b1;
                        for (int i = 0; i < 4; i++)
                            win_next[i] = '0;
                        seen_next = '0;
                    end
                    else
                    begin
                        win_next[3] = win_reg[2];
                        win_next[2] = win_reg[1];
                        win_next[1] = win_reg[0];
                        win_next[0] = x;
                        seen_next = (seen_reg >= 3'd4) ? 3'd4 : seen_reg + 3'd1;
                    end
                    njob_next = n;
                    jidx_next = '0;
                    if (n != 2'd0)
                        state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                cmd.start = 1'b1;
                cmd.nd    = jobs_reg[jidx_reg];
                state_next = S_RUN;
            end
            S_RUN:
            begin
                if (sts.done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                // output register free: load it and go on
                if (!ov_reg || out_ready)
                begin
                    ov_next  = 1'b1;
                    ovv_next = dp_value;
                    ovl_next = dp_last;
                    ovs_next = dp_sat;
                    if (jidx_reg + 2'd1 == njob_reg)
                        state_next = S_IDLE;
                    else
                    begin
                        jidx_next  = jidx_reg + 2'd1;
                        state_next = S_NEXT;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int i = 0; i < 4; i++)
                win_reg[i] <= '0;
            seen_reg  <= '0;
            njob_reg  <= '0;
            jidx_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            win_reg   <= win_next;
            seen_reg  <= seen_next;
            njob_reg  <= njob_next;
            jidx_reg  <= jidx_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        jobs_reg <= jobs_next;
        ovv_reg  <= ovv_next;
        ovl_reg  <= ovl_next;
        ovs_reg  <= ovs_next;
    end

    assign out_valid = ov_reg;
    assign out_value = ovv_reg;
    assign out_last  = ovl_reg;
    assign out_sat   = ovs_reg;

`ifndef SYNTHESIS
    a_seen_cap: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= 3'd4) else $error("sample count overflow");
    a_job_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (jidx_reg < njob_reg)) else $error("bad job index");
    a_start_idle_dp: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !sts.busy) else $error("start while busy");
`endif

endmodule

>>> sv/ks_stencil_rhs_unit.sv
// ----------------------------------------------------------------------------
// ks_stencil_rhs_unit: streamed Kuramoto-Sivashinsky right-hand side
// Usage:
//   in channel beat: {last_sample, sample}; out channel beat:
//   {saturated, last_result, rhs_value}. config: cfg_we, cfg_idx, cfg_data
//   (0 dx_inv, 1 mu_advection, 2 mu_hyperdiffusion), only while idle.
// Each sample produces zero to three results; the final sample of a grid
// flushes the remaining nodes and marks the last one.
// Flow: a sample is taken only while the sequencer is idle; each node is then
// issued to the datapath, run through the fixed 31-step program on the single
// shared multiply/add unit, signalled done and loaded into the output register,
// which waits on a stalled receiver. A final sample with three nodes holds the
// input off until its third result is loaded. A sample with no node is taken at once.
// Reset clears the window, count, sequencer and output valid flag; the config
// registers return to 1.0. A stalled receiver holds the output register and
// the block waits before loading the next result, without losing any.
// ----------------------------------------------------------------------------
module ks_stencil_rhs_unit
    import ksr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    ksr_stream_if.sink            in_ch,
    ksr_stream_if.source          out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [30:0] dx_reg;
    q_t          mua_reg, muh_reg;
    dp_cmd_t     cmd;
    dp_sts_t     sts;
    q_t          dp_value;
    logic        dp_last, dp_sat;
    q_t          o_val;
    logic        o_last, o_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dx_reg  <= 31'(ONE);
            mua_reg <= ONE;
            muh_reg <= ONE;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_DX_INV: dx_reg  <= cfg_data[30:0];
                REG_MU_ADV: mua_reg <= q_t'(cfg_data);
                REG_MU_HYP: muh_reg <= q_t'(cfg_data);
                default: ;
            endcase
        end
    end

    ksr_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .in_sample(q_t'(in_ch.data[31:0])), .in_last(in_ch.data[32]),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .out_value(o_val), .out_last(o_last), .out_sat(o_sat),
        .cmd(cmd), .sts(sts),
        .dp_value(dp_value), .dp_last(dp_last), .dp_sat(dp_sat)
    );

    ksr_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .dx_inv(dx_reg), .mu_adv(mua_reg), .mu_hyp(muh_reg),
        .res_value(dp_value), .res_last(dp_last), .res_sat(dp_sat)
    );

    assign out_ch.data = {o_sat, o_last, o_val};

endmodule
